@@ hdl/kmbp_pkg.sv @@
// Package for the keyboard and mouse byte parser.
// Holds the parse phase, command and event codes, the item and result types
// and the group shift table. No dependencies.
package kmbp_pkg;

   // queue between front and back, and the result queue
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // geometry of the link payload and of a mouse move
   localparam int GROUP_BITS      = 7;
   localparam int KEY_COUNT       = 128;
   localparam int GROUPS_PER_AXIS = 5;
   localparam int GROUPS_TOTAL    = 10;
   localparam int MOVE_WIDTH      = 32;

   // command codes carried in the low bits of a command byte
   localparam logic [GROUP_BITS-1:0] CMD_CODE_PRESS   = 7'h00;
   localparam logic [GROUP_BITS-1:0] CMD_CODE_RELEASE = 7'h01;
   localparam logic [GROUP_BITS-1:0] CMD_CODE_BUTTONS = 7'h02;
   localparam logic [GROUP_BITS-1:0] CMD_CODE_MOVE    = 7'h03;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_PRESS   = 3'd1,
      PH_RELEASE = 3'd2,
      PH_BUTTONS = 3'd3,
      PH_MOVE    = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      EV_PRESS     = 3'd0,
      EV_RELEASE   = 3'd1,
      EV_BUTTONS   = 3'd2,
      EV_MOVE      = 3'd3,
      EV_VIOLATION = 3'd4,
      EV_UNKNOWN   = 3'd5
   } event_type;

   typedef enum logic [2:0] {
      CMD_PRESS   = 3'd0,
      CMD_RELEASE = 3'd1,
      CMD_BUTTONS = 3'd2,
      CMD_MOVE    = 3'd3,
      CMD_UNKNOWN = 3'd4
   } cmd_type;

   // classified byte as it travels from front to back
   typedef struct packed {
      logic                  is_cmd;
      cmd_type               cmd;
      logic [GROUP_BITS-1:0] payload;
   } item_type;

   // one result item
   typedef struct packed {
      event_type                    event_kind;
      logic [GROUP_BITS-1:0]        key_code;
      logic [GROUP_BITS-1:0]        button_bits;
      logic signed [MOVE_WIDTH-1:0] move_dx;
      logic signed [MOVE_WIDTH-1:0] move_dy;
   } rsp_type;

   // bit position of a 7-bit group within its axis
   function automatic logic [4:0] group_shift(input logic [2:0] lane);
      logic [4:0] shift;
      unique case (lane)
         3'd0:    shift = 5'd0;
         3'd1:    shift = 5'd7;
         3'd2:    shift = 5'd14;
         3'd3:    shift = 5'd21;
         3'd4:    shift = 5'd28;
         default: shift = 5'd0;
      endcase
      return shift;
   endfunction

endpackage

@@ hdl/kmbp_queue.sv @@
// Small first-in first-out queue with show-ahead output.
// Generic register storage; used between front and back and for results.
// No package dependencies.
module kmbp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] data_in,
   output logic             full,
   output logic             empty,
   input  logic             pop,
   output logic [WIDTH-1:0] data_out
);
   localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountWidth = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]      store_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = (count_ff == CountWidth'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = store_ff[rd_ptr_ff];

   // pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= data_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(DEPTH))
      else $error("queue occupancy beyond depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue push lost");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue pop lost");

endmodule

@@ hdl/kmbp_front.sv @@
// Front end: accepts received bytes, classifies them as data or command and
// queues them for the back end. Depends on kmbp_pkg and kmbp_queue.
module kmbp_front #(
   parameter int QUEUE_DEPTH = kmbp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [7:0]         req_rx_byte,
   output logic               item_empty,
   input  logic               item_pop,
   output kmbp_pkg::item_type item
);
   import kmbp_pkg::*;

   item_type cls_item;
   logic [$bits(item_type)-1:0] queue_out;

   // decode the command code from every byte; the back end uses it only for commands
   always_comb begin
      cls_item.is_cmd  = req_rx_byte[7];
      cls_item.payload = req_rx_byte[GROUP_BITS-1:0];
      unique case (req_rx_byte[GROUP_BITS-1:0])
         CMD_CODE_PRESS:   cls_item.cmd = CMD_PRESS;
         CMD_CODE_RELEASE: cls_item.cmd = CMD_RELEASE;
         CMD_CODE_BUTTONS: cls_item.cmd = CMD_BUTTONS;
         CMD_CODE_MOVE:    cls_item.cmd = CMD_MOVE;
         default:          cls_item.cmd = CMD_UNKNOWN;
      endcase
   end

   kmbp_queue #(
      .WIDTH ($bits(item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_item_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .data_in  (cls_item),
      .full     (req_full),
      .empty    (item_empty),
      .pop      (item_pop),
      .data_out (queue_out)
   );

   assign item = item_type'(queue_out);

endmodule

@@ hdl/kmbp_back.sv @@
// Back end: parse state machine, key table, button state and move
// accumulators; results go to a result queue. Depends on kmbp_pkg, kmbp_queue.
module kmbp_back #(
   parameter int QUEUE_DEPTH = kmbp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_empty,
   output logic               item_pop,
   input  kmbp_pkg::item_type item,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output kmbp_pkg::rsp_type  rsp
);
   import kmbp_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [3:0]            group_count_ff, group_count_in;
   logic [MOVE_WIDTH-1:0] dx_accum_ff, dx_accum_in;
   logic [MOVE_WIDTH-1:0] dy_accum_ff, dy_accum_in;
   logic [KEY_COUNT-1:0]  key_down_ff, key_down_in;
   logic [GROUP_BITS-1:0] buttons_ff, buttons_in;

   logic                  take;
   logic                  out_full;
   logic                  out_valid;
   rsp_type               out_rsp;
   logic [4:0]            group_inc;
   logic                  move_done;
   logic [2:0]            lane;
   logic [MOVE_WIDTH-1:0] group_val;
   logic [$bits(rsp_type)-1:0] queue_out;

   assign take     = !item_empty && !out_full;
   assign item_pop = take;

   // placement of the incoming 7-bit move group
   assign group_inc = {1'b0, group_count_ff} + 5'd1;
   assign move_done = (group_inc >= 5'(GROUPS_TOTAL));
   assign lane      = (group_count_ff < 4'(GROUPS_PER_AXIS))
                      ? group_count_ff[2:0]
                      : 3'(group_count_ff - 4'(GROUPS_PER_AXIS));
   assign group_val = MOVE_WIDTH'(item.payload) << group_shift(lane);

   // next parse phase
   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         unique case (phase_ff)
            PH_PRESS, PH_RELEASE, PH_BUTTONS: phase_in = PH_IDLE;
            PH_MOVE: begin
               phase_in = (item.is_cmd || move_done) ? PH_IDLE : PH_MOVE;
            end
            default: begin
               phase_in = PH_IDLE;
               if (item.is_cmd) begin
                  unique case (item.cmd)
                     CMD_PRESS:   phase_in = PH_PRESS;
                     CMD_RELEASE: phase_in = PH_RELEASE;
                     CMD_BUTTONS: phase_in = PH_BUTTONS;
                     CMD_MOVE:    phase_in = PH_MOVE;
                     default:     phase_in = PH_IDLE;
                  endcase
               end
            end
         endcase
      end
   end

   // state updates: key table, buttons, move accumulators
   always_comb begin
      group_count_in = group_count_ff;
      dx_accum_in    = dx_accum_ff;
      dy_accum_in    = dy_accum_ff;
      key_down_in    = key_down_ff;
      buttons_in     = buttons_ff;
      if (take) begin
         unique case (phase_ff)
            PH_PRESS: begin
               if (!item.is_cmd) key_down_in[item.payload] = 1'b1;
            end
            PH_RELEASE: begin
               if (!item.is_cmd) key_down_in[item.payload] = 1'b0;
            end
            PH_BUTTONS: begin
               if (!item.is_cmd) buttons_in = item.payload;
            end
            PH_MOVE: begin
               if (!item.is_cmd) begin
                  if (group_count_ff < 4'(GROUPS_PER_AXIS)) begin
                     dx_accum_in = dx_accum_ff | group_val;
                  end else if (group_count_ff < 4'(GROUPS_TOTAL)) begin
                     dy_accum_in = dy_accum_ff | group_val;
                  end
                  group_count_in = group_inc[3:0];
               end
            end
            default: begin
               if (item.is_cmd && item.cmd == CMD_MOVE) begin
                  group_count_in = '0;
                  dx_accum_in    = '0;
                  dy_accum_in    = '0;
               end
            end
         endcase
      end
   end

   // result item for this step
   always_comb begin
      out_valid           = 1'b0;
      out_rsp             = '0;
      out_rsp.event_kind  = EV_PRESS;
      out_rsp.button_bits = buttons_in;
      if (take) begin
         unique case (phase_ff)
            PH_PRESS, PH_RELEASE, PH_BUTTONS, PH_MOVE: begin
               if (item.is_cmd) begin
                  out_valid          = 1'b1;
                  out_rsp.event_kind = EV_VIOLATION;
               end else if (phase_ff == PH_PRESS) begin
                  out_valid          = 1'b1;
                  out_rsp.event_kind = EV_PRESS;
                  out_rsp.key_code   = item.payload;
               end else if (phase_ff == PH_RELEASE) begin
                  out_valid          = 1'b1;
                  out_rsp.event_kind = EV_RELEASE;
                  out_rsp.key_code   = item.payload;
               end else if (phase_ff == PH_BUTTONS) begin
                  out_valid          = 1'b1;
                  out_rsp.event_kind = EV_BUTTONS;
               end else if (move_done) begin
                  out_valid          = 1'b1;
                  out_rsp.event_kind = EV_MOVE;
                  out_rsp.move_dx    = dx_accum_in;
                  out_rsp.move_dy    = dy_accum_in;
               end
            end
            default: begin
               if (item.is_cmd && item.cmd == CMD_UNKNOWN) begin
                  out_valid          = 1'b1;
                  out_rsp.event_kind = EV_UNKNOWN;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         group_count_ff <= '0;
         dx_accum_ff    <= '0;
         dy_accum_ff    <= '0;
         key_down_ff    <= '0;
         buttons_ff     <= '0;
      end else begin
         phase_ff       <= phase_in;
         group_count_ff <= group_count_in;
         dx_accum_ff    <= dx_accum_in;
         dy_accum_ff    <= dy_accum_in;
         key_down_ff    <= key_down_in;
         buttons_ff     <= buttons_in;
      end
   end

   kmbp_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (out_valid),
      .data_in  (out_rsp),
      .full     (out_full),
      .empty    (rsp_empty),
      .pop      (rsp_pop),
      .data_out (queue_out)
   );

   assign rsp = rsp_type'(queue_out);

   a_press_sets_key: assert property (@(posedge clock) disable iff (reset)
      (take && phase_ff == PH_PRESS && !item.is_cmd)
      |=> key_down_ff[$past(item.payload)])
      else $error("key press not recorded");

   a_violation_not_idle: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_rsp.event_kind == EV_VIOLATION) |-> (phase_ff != PH_IDLE))
      else $error("violation raised while idle");

   a_group_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_MOVE) |-> (group_count_ff < 4'(GROUPS_TOTAL)))
      else $error("move group count overran");

endmodule

@@ hdl/keyboard_mouse_byte_parser_unit.sv @@
// Top level of the keyboard and mouse byte parser.
// Depends on kmbp_pkg, kmbp_front and kmbp_back.
//
// Usage:
//   Input channel: one received byte per item on req_rx_byte, taken at a
//   rising edge with req_push high and req_full low.
//   Result channel: the oldest result item sits on the rsp_ ports while
//   rsp_empty is low and is taken at a rising edge with rsp_pop high.
//   Each byte gives zero or one result: key press or release, button
//   change, a completed mouse move (after its tenth data byte), a protocol
//   violation or an unknown command.
// Timing:
//   One item per cycle sustained while the result queue has room. A
//   result reaches the rsp_ ports through the front queue, then the
//   parse state machine takes its byte and writes the result queue. It
//   sets the rate: one byte a cycle while the result queue has room.
// Reset:
//   Synchronous reset empties both queues, returns the parser to idle and
//   clears the key table, button state and move accumulators.
// Stalls:
//   If rsp_pop stays low the result queue fills, the parser stops taking
//   bytes, the front queue fills and req_full rises. Nothing is dropped.
module keyboard_mouse_byte_parser_unit #(
   parameter int QUEUE_DEPTH = kmbp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [2:0]         rsp_event_kind,
   output logic [6:0]         rsp_key_code,
   output logic [6:0]         rsp_button_bits,
   output logic signed [31:0] rsp_move_dx,
   output logic signed [31:0] rsp_move_dy
);
   import kmbp_pkg::*;

   logic     item_empty;
   logic     item_pop;
   item_type item;
   rsp_type  rsp;

   kmbp_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_rx_byte (req_rx_byte),
      .item_empty  (item_empty),
      .item_pop    (item_pop),
      .item        (item)
   );

   kmbp_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_empty (item_empty),
      .item_pop   (item_pop),
      .item       (item),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp        (rsp)
   );

   assign rsp_event_kind  = rsp.event_kind;
   assign rsp_key_code    = rsp.key_code;
   assign rsp_button_bits = rsp.button_bits;
   assign rsp_move_dx     = rsp.move_dx;
   assign rsp_move_dy     = rsp.move_dy;

endmodule
